// File: hw/rtl/rld_pkg.sv
// Package for the rotary ladder decoder: payload structs, register indexes and constants.
// Used by rotary_ladder_decoder; depends on nothing else.
package rld_pkg;

    localparam int MAX_POSITIONS = 6;
    localparam int CENTER_SLOTS  = 6;
    localparam logic [15:0] ERR_MAX = 16'hffff;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CENTERS_01        = 3'd0,
        REG_CENTERS_23        = 3'd1,
        REG_CENTERS_45        = 3'd2,
        REG_POSITION_COUNT    = 3'd3,
        REG_HYSTERESIS_MARGIN = 3'd4,
        REG_MAX_ERROR         = 3'd5,
        REG_DEBOUNCE_TIME     = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] sample;
        logic [31:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic [2:0] stable_pos;
        logic       ladder_ok;
    } out_item_t;

endpackage

// File: hw/rtl/rotary_ladder_decoder.sv
// Top level of the rotary ladder decoder: input register, decode and debounce, result register.
// Depends on rld_pkg for payload types, register indexes and constants.
// The block takes one sample transfer per clock unless out_ready holds a result, and presents
// its result from an output register behind the input register. While a result waits to be
// taken, one further sample can still be held in the input register, after which in_ready
// stays low until the result moves on. The critical path runs through the ladder check, the
// six-step nearest-centre search and the debounce compare. Any write to an existing register
// clears the candidate and stable state; a write to an index beyond the list is ignored.
module rotary_ladder_decoder #(
    parameter int MAX_POSITIONS = rld_pkg::MAX_POSITIONS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [rld_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [rld_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  rld_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output rld_pkg::out_item_t                   out_data
);

    localparam int LIMIT = (MAX_POSITIONS < rld_pkg::CENTER_SLOTS) ?
                           MAX_POSITIONS : rld_pkg::CENTER_SLOTS;

    logic [31:0] centers_01_reg;
    logic [31:0] centers_23_reg;
    logic [31:0] centers_45_reg;
    logic [2:0]  position_count_reg;
    logic [15:0] hysteresis_margin_reg;
    logic [15:0] max_error_reg;
    logic [31:0] debounce_time_reg;

    logic [2:0]  candidate_pos_reg;
    logic [2:0]  candidate_pos_next;
    logic [2:0]  stable_position_reg;
    logic [2:0]  stable_position_next;
    logic [31:0] candidate_time_reg;
    logic [31:0] candidate_time_next;

    logic              in_valid_reg;
    rld_pkg::in_item_t in_data_reg;
    logic               out_valid_reg;
    rld_pkg::out_item_t out_data_reg;

    logic        advance;
    logic        cfg_hit;
    logic [15:0] centers [rld_pkg::CENTER_SLOTS];
    logic        ladder_ok;
    logic [2:0]  nearest_pos;
    logic [2:0]  decoded;

    function automatic logic [15:0] dist16(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign centers[0] = centers_01_reg[15:0];
    assign centers[1] = centers_01_reg[31:16];
    assign centers[2] = centers_23_reg[15:0];
    assign centers[3] = centers_23_reg[31:16];
    assign centers[4] = centers_45_reg[15:0];
    assign centers[5] = centers_45_reg[31:16];

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        logic falling;
        ladder_ok = (position_count_reg >= 3'd2) && (position_count_reg <= 3'(LIMIT));
        falling = centers[1] < centers[0];
        for (int i = 0; i < rld_pkg::CENTER_SLOTS - 1; i++)
        begin
            if (3'(i + 1) < position_count_reg)
            begin
                if (falling ? (centers[i] <= centers[i+1]) : (centers[i] >= centers[i+1]))
                begin
                    ladder_ok = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        logic [2:0]  best;
        logic [15:0] best_err;
        logic [15:0] err;
        best = 3'd0;
        best_err = rld_pkg::ERR_MAX;
        for (int i = 0; i < rld_pkg::CENTER_SLOTS; i++)
        begin
            err = dist16(in_data_reg.sample, centers[i]);
            if ((3'(i) < position_count_reg) && (err < best_err))
            begin
                best_err = err;
                best = 3'(i + 1);
            end
        end
        nearest_pos = (best_err <= max_error_reg) ? best : 3'd0;
    end

    always_comb
    begin
        logic [16:0] tol_sum;
        logic [15:0] tol;
        logic [2:0]  stable_idx;
        logic [15:0] stable_center;
        tol_sum = {1'b0, max_error_reg} + {1'b0, hysteresis_margin_reg};
        tol = tol_sum[16] ? rld_pkg::ERR_MAX : tol_sum[15:0];
        stable_idx = stable_position_reg - 3'd1;
        stable_center = (stable_idx < 3'(rld_pkg::CENTER_SLOTS)) ? centers[stable_idx] : 16'd0;
        if (!ladder_ok)
        begin
            decoded = 3'd0;
        end
        else if ((stable_position_reg != 3'd0) && (stable_position_reg <= position_count_reg))
        begin
            decoded = (dist16(in_data_reg.sample, stable_center) <= tol) ?
                      stable_position_reg : nearest_pos;
        end
        else
        begin
            decoded = nearest_pos;
        end
    end

    always_comb
    begin
        logic [31:0] elapsed;
        candidate_pos_next  = candidate_pos_reg;
        candidate_time_next = candidate_time_reg;
        if (decoded != candidate_pos_reg)
        begin
            candidate_pos_next  = decoded;
            candidate_time_next = in_data_reg.now_time;
        end
        elapsed = in_data_reg.now_time - candidate_time_next;
        stable_position_next = stable_position_reg;
        if ((decoded != stable_position_reg) && (elapsed >= debounce_time_reg))
        begin
            stable_position_next = decoded;
        end
    end

    assign cfg_hit = cfg_write && (cfg_index <= rld_pkg::REG_DEBOUNCE_TIME);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centers_01_reg        <= '0;
            centers_23_reg        <= '0;
            centers_45_reg        <= '0;
            position_count_reg    <= '0;
            hysteresis_margin_reg <= '0;
            max_error_reg         <= '0;
            debounce_time_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rld_pkg::REG_CENTERS_01:        centers_01_reg        <= cfg_data;
                rld_pkg::REG_CENTERS_23:        centers_23_reg        <= cfg_data;
                rld_pkg::REG_CENTERS_45:        centers_45_reg        <= cfg_data;
                rld_pkg::REG_POSITION_COUNT:    position_count_reg    <= cfg_data[2:0];
                rld_pkg::REG_HYSTERESIS_MARGIN: hysteresis_margin_reg <= cfg_data[15:0];
                rld_pkg::REG_MAX_ERROR:         max_error_reg         <= cfg_data[15:0];
                rld_pkg::REG_DEBOUNCE_TIME:     debounce_time_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            candidate_pos_reg   <= '0;
            stable_position_reg <= '0;
            candidate_time_reg  <= '0;
        end
        else if (cfg_hit)
        begin
            candidate_pos_reg   <= '0;
            stable_position_reg <= '0;
            candidate_time_reg  <= '0;
        end
        else if (advance)
        begin
            candidate_pos_reg   <= candidate_pos_next;
            stable_position_reg <= stable_position_next;
            candidate_time_reg  <= candidate_time_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg.stable_pos <= stable_position_next;
            out_data_reg.ladder_ok  <= ladder_ok;
        end
    end

`ifndef NO_ASSERTIONS
    a_cfg_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (stable_position_reg == 3'd0) && (candidate_pos_reg == 3'd0)
                    && (candidate_time_reg == 32'd0))
        else $error("State not cleared after a configuration write.");

    a_stable_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        stable_position_reg <= 3'(LIMIT))
        else $error("Stable position beyond the ladder limit.");

    a_held_result_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("Input taken while a pending transfer cannot move on.");

    a_new_candidate_time: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cfg_hit && (decoded != candidate_pos_reg))
        |=> (candidate_time_reg == $past(in_data_reg.now_time)))
        else $error("New candidate did not take the sample timestamp.");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for rotary_ladder_decoder: directed and random sample transfers
// against a built-in position predictor. Depends on rld_pkg and the rotary_ladder_decoder RTL.
module tb_top;

    localparam logic [rld_pkg::CFG_INDEX_W-1:0] REG_UNLISTED = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int RANDOM_PHASES = 12;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_write = 1'b0;
    logic [rld_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rld_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    rld_pkg::in_item_t               in_data = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    rld_pkg::out_item_t              out_data;

    bit steady = 1'b0;
    int mismatches = 0;
    int stall_cycles = 0;
    logic [31:0] clock_ms = '0;

    // Predictor copy of the registers and the debounce state.
    logic [31:0] centre_word [3] = '{default: '0};
    logic [2:0]  detent_count = '0;
    logic [15:0] hyst_margin = '0;
    logic [15:0] max_err = '0;
    logic [31:0] settle_ms = '0;
    logic [2:0]  pred_candidate = '0;
    logic [2:0]  pred_stable = '0;
    logic [31:0] pred_cand_time = '0;

    rld_pkg::out_item_t pending_positions [$];

    rotary_ladder_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 7);
    end

    function automatic logic [15:0] centre_at(input int slot);
        logic [31:0] word;
        word = centre_word[slot / 2];
        return (slot % 2) ? word[31:16] : word[15:0];
    endfunction

    function automatic int distance(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    function automatic bit ladder_is_valid();
        int  limit;
        bit  falling;
        limit = (rld_pkg::MAX_POSITIONS < rld_pkg::CENTER_SLOTS) ?
                rld_pkg::MAX_POSITIONS : rld_pkg::CENTER_SLOTS;
        if (detent_count < 2 || detent_count > limit)
            return 1'b0;
        falling = centre_at(1) < centre_at(0);
        for (int i = 0; i + 1 < detent_count; i++)
        begin
            if (falling ? (centre_at(i) <= centre_at(i + 1)) : (centre_at(i) >= centre_at(i + 1)))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [2:0] nearest_detent(input logic [15:0] reading);
        logic [2:0] best;
        int         best_err;
        int         err;
        best = '0;
        best_err = int'(rld_pkg::ERR_MAX);
        for (int i = 0; i < detent_count && i < rld_pkg::CENTER_SLOTS; i++)
        begin
            err = distance(reading, centre_at(i));
            if (err < best_err)
            begin
                best_err = err;
                best = 3'(i + 1);
            end
        end
        return (best_err <= int'(max_err)) ? best : 3'd0;
    endfunction

    function automatic rld_pkg::out_item_t decode_reading(input rld_pkg::in_item_t item);
        bit                 ok;
        logic [2:0]         decoded;
        int                 tol;
        rld_pkg::out_item_t res;
        ok = ladder_is_valid();
        if (!ok)
            decoded = '0;
        else if (pred_stable >= 1 && pred_stable <= detent_count)
        begin
            tol = int'(max_err) + int'(hyst_margin);
            if (tol > int'(rld_pkg::ERR_MAX))
                tol = int'(rld_pkg::ERR_MAX);
            if (distance(item.sample, centre_at(int'(pred_stable) - 1)) <= tol)
                decoded = pred_stable;
            else
                decoded = nearest_detent(item.sample);
        end
        else
            decoded = nearest_detent(item.sample);
        if (decoded != pred_candidate)
        begin
            pred_candidate = decoded;
            pred_cand_time = item.now_time;
        end
        if (decoded != pred_stable && 32'(item.now_time - pred_cand_time) >= settle_ms)
            pred_stable = decoded;
        res.stable_pos = pred_stable;
        res.ladder_ok = ok;
        return res;
    endfunction

    function automatic void apply_reg(input logic [rld_pkg::CFG_INDEX_W-1:0] idx,
                                      input logic [rld_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            rld_pkg::REG_CENTERS_01:        centre_word[0] = data;
            rld_pkg::REG_CENTERS_23:        centre_word[1] = data;
            rld_pkg::REG_CENTERS_45:        centre_word[2] = data;
            rld_pkg::REG_POSITION_COUNT:    detent_count = data[2:0];
            rld_pkg::REG_HYSTERESIS_MARGIN: hyst_margin = data[15:0];
            rld_pkg::REG_MAX_ERROR:         max_err = data[15:0];
            rld_pkg::REG_DEBOUNCE_TIME:     settle_ms = data;
            default:                        return;
        endcase
        pred_candidate = '0;
        pred_stable = '0;
        pred_cand_time = '0;
    endfunction

    function automatic void note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    // Everything is sampled at the falling edge, clear of the driving edge; a transfer seen
    // here completes at the next rising edge.
    always @(negedge clk)
    begin : monitor
        rld_pkg::out_item_t want;
        bit                 moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                if (pending_positions.size() == 0)
                    note_mismatch("unexpected result", -1, int'(out_data.stable_pos));
                else
                begin
                    want = pending_positions.pop_front();
                    if (out_data.stable_pos !== want.stable_pos)
                        note_mismatch("stable_pos", int'(want.stable_pos),
                                      int'(out_data.stable_pos));
                    if (out_data.ladder_ok !== want.ladder_ok)
                        note_mismatch("ladder_ok", int'(want.ladder_ok),
                                      int'(out_data.ladder_ok));
                end
            end
            if (cfg_write)
            begin
                moved = 1'b1;
                apply_reg(cfg_index, cfg_data);
            end
            if (in_valid && in_ready)
            begin
                moved = 1'b1;
                pending_positions.push_back(decode_reading(in_data));
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
        end
    end

    task automatic send_reading(input logic [15:0] reading, input logic [31:0] stamp);
        bit taken;
        if (!steady && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.sample <= reading;
        in_data.now_time <= stamp;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_positions.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rld_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic finish_cfg();
        cfg_write <= 1'b0;
    endtask

    task automatic set_ladder(input logic [31:0] c01, input logic [31:0] c23,
                              input logic [31:0] c45, input logic [31:0] count,
                              input logic [31:0] hyst, input logic [31:0] maxe,
                              input logic [31:0] settle);
        wait_for_results();
        write_reg(rld_pkg::REG_CENTERS_01, c01);
        write_reg(rld_pkg::REG_CENTERS_23, c23);
        write_reg(rld_pkg::REG_CENTERS_45, c45);
        write_reg(rld_pkg::REG_POSITION_COUNT, count);
        write_reg(rld_pkg::REG_HYSTERESIS_MARGIN, hyst);
        write_reg(rld_pkg::REG_MAX_ERROR, maxe);
        write_reg(rld_pkg::REG_DEBOUNCE_TIME, settle);
        finish_cfg();
    endtask

    task automatic test_reset_defaults();
        send_reading(16'h0000, 32'h0000_0000);
        send_reading(16'hFFFF, 32'hFFFF_FFFF);
        send_reading(16'h5A5A, 32'h0000_0001);
    endtask

    // A single detent, a count beyond six, equal centres and a reversing ladder all decode as 0.
    task automatic test_invalid_ladders();
        set_ladder(32'h2000_1000, 32'h4000_3000, 32'h6000_5000, 32'hFFFF_FFF9,
                   32'h0, 32'h1000, 32'h0);
        send_reading(16'h1000, 32'd10);
        set_ladder(32'h2000_1000, 32'h4000_3000, 32'h6000_5000, 32'd7, 32'h0, 32'h1000, 32'h0);
        send_reading(16'h2000, 32'd11);
        set_ladder(32'h1000_1000, 32'h4000_3000, 32'h6000_5000, 32'd3, 32'h0, 32'h1000, 32'h0);
        send_reading(16'h1000, 32'd12);
        set_ladder(32'h3000_1000, 32'h4000_2000, 32'h6000_5000, 32'd3, 32'h0, 32'h1000, 32'h0);
        send_reading(16'h3000, 32'd13);
    endtask

    task automatic test_rising_ladder();
        set_ladder(32'h2000_0000, 32'h8000_5000, 32'hFFFF_B000, 32'd6,
                   32'hABCD_0800, 32'h0400, 32'd3);
        send_reading(16'h0000, 32'd100);
        send_reading(16'h0010, 32'd103);
        send_reading(16'h0C00, 32'd104);
        send_reading(16'h1000, 32'd105);
        send_reading(16'h2000, 32'd106);
        send_reading(16'h2000, 32'd109);
        send_reading(16'hFFFF, 32'd110);
        send_reading(16'hFFFF, 32'd120);
    endtask

    // Falling ladder with a saturated tolerance, an equal-distance tie and a timer wrap.
    task automatic test_falling_ladder();
        set_ladder(32'hC000_F000, 32'h6000_9000, 32'h0000_3000, 32'd6,
                   32'hFFFF, 32'hFFFF, 32'd0);
        send_reading(16'hA800, 32'hFFFF_FFFE);
        send_reading(16'h0000, 32'hFFFF_FFFF);
        send_reading(16'h4800, 32'h0000_0002);
    endtask

    // A write to the index beyond the register list must leave the debounce state alone.
    task automatic test_unlisted_index();
        set_ladder(32'h0000_FFFF, 32'h0, 32'h0, 32'd2, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_reading(16'hFFFF, 32'd5);
        send_reading(16'hFFFF, 32'd4);
        wait_for_results();
        write_reg(REG_UNLISTED, 32'hFFFF_FFFF);
        finish_cfg();
        send_reading(16'hFFFF, 32'd5);
        send_reading(16'h0001, 32'd6);
        send_reading(16'h0000, 32'd7);
    endtask

    task automatic test_random_traffic();
        int c [6];
        int n, base, step, j, tmp, maxe, hyst, spread, off, v, target, hold, pick;
        logic [31:0] settle;
        logic [31:0] dt;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 6);
            base = $urandom_range(0, 4000);
            step = $urandom_range(1, (65535 - base) / 6);
            for (j = 0; j < 6; j++)
                c[j] = base + j * step + $urandom_range(0, step - 1);
            if ($urandom_range(0, 9) == 0)
            begin
                j = $urandom_range(0, 4);
                c[j + 1] = c[j];
            end
            if ($urandom_range(0, 1) == 1)
            begin
                for (j = 0; j < 3; j++)
                begin
                    tmp = c[j];
                    c[j] = c[5 - j];
                    c[5 - j] = tmp;
                end
            end
            case ($urandom_range(0, 3))
                0:       maxe = 0;
                1:       maxe = $urandom_range(0, step / 2);
                2:       maxe = $urandom_range(0, (step * 2 > 65535) ? 65535 : step * 2);
                default: maxe = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 3))
                0:       hyst = 0;
                1:       hyst = $urandom_range(0, step / 2);
                2:       hyst = $urandom_range(0, step);
                default: hyst = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 7))
                0:       settle = 32'd0;
                1:       settle = $urandom();
                2:       settle = $urandom_range(0, 40);
                default: settle = $urandom_range(1, 8);
            endcase
            if (phase == 0)
            begin
                maxe = 0;
                hyst = 0;
                settle = 32'd0;
            end
            else if (phase == 1)
            begin
                maxe = 65535;
                hyst = 65535;
                settle = 32'hFFFF_FFFF;
            end
            steady = (phase == 4);
            set_ladder({c[1][15:0], c[0][15:0]}, {c[3][15:0], c[2][15:0]},
                       {c[5][15:0], c[4][15:0]}, 32'(n), 32'(hyst), 32'(maxe), settle);
            clock_ms = (phase % 3 == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200) : $urandom();
            hold = 0;
            target = 0;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (hold == 0)
                begin
                    target = $urandom_range(0, 5);
                    hold = $urandom_range(1, 12);
                end
                hold--;
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    spread = maxe + hyst + 64;
                    if (spread > 65535)
                        spread = 65535;
                    off = $urandom_range(0, spread);
                    v = ($urandom_range(0, 1) == 1) ? c[target] + off : c[target] - off;
                end
                else if (pick < 85)
                    v = $urandom_range(0, 65535);
                else if (pick < 90)
                    v = 0;
                else if (pick < 95)
                    v = 65535;
                else
                    v = (c[target] + c[(target + 1) % 6]) / 2;
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
                case ($urandom_range(0, 9))
                    6:       dt = settle;
                    7:       dt = settle - 32'd1;
                    8:       dt = $urandom_range(0, 1000);
                    9:       dt = $urandom();
                    default: dt = $urandom_range(0, 3);
                endcase
                clock_ms = clock_ms + dt;
                send_reading(16'(v), clock_ms);
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin : watchdog
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_invalid_ladders();
        test_rising_ladder();
        test_falling_ladder();
        test_unlisted_index();
        test_random_traffic();
        wait_for_results();
        repeat (5) @(posedge clk);
        if (mismatches == 0 && pending_positions.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/rld_pkg.sv
hw/rtl/rotary_ladder_decoder.sv
sim/tb_top.sv
